>>> rtl/tks_pkg.sv
package tks_pkg;

  // sizing
  localparam int MAX_KEEP   = 16;
  localparam int MAX_VECTOR = 1024;
  localparam int SCORE_W    = 16;
  localparam int IDX_W      = 10;
  localparam int POS_W      = $clog2(MAX_VECTOR);
  localparam int KEEP_W     = $clog2(MAX_KEEP + 1);
  localparam int KEEP_CFG_W = 5;
  localparam int REG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [REG_ADDR_W-1:0] REG_KEEP_COUNT      = 1'b0;
  localparam logic [REG_ADDR_W-1:0] REG_SCORE_THRESHOLD = 1'b1;

  typedef enum logic {
    ST_COLLECT,
    ST_DRAIN
  } state_e;

  // what a cell shows its neighbors
  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [POS_W-1:0]   index;
    logic               valid;  // entry held
    logic               kept;   // entry held and within the keep window
    logic               beat;   // new score goes at or before this cell
  } link_t;

  // per-cycle commands broadcast to every cell
  typedef struct packed {
    logic ins;    // insert the new score
    logic trim;   // drop entries beyond the keep window
    logic shift;  // move entries one cell toward the head
    logic clear;  // empty the chain
  } cell_ctl_t;

endpackage

>>> rtl/tks_cell.sv
module tks_cell
  import tks_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cell_ctl_t          ctl_i,
  input  logic               in_keep_i,
  input  logic [SCORE_W-1:0] new_score_i,
  input  logic [POS_W-1:0]   new_index_i,
  input  link_t              prev_i,
  input  link_t              next_i,
  output link_t              link_o
);

  logic [SCORE_W-1:0] score_q, score_d;
  logic [POS_W-1:0]   index_q, index_d;
  logic               valid_q, valid_d;
  logic               kept;
  logic               beat;

  // strict compare keeps the earlier entry on a tie
  assign kept = valid_q & in_keep_i;
  assign beat = !kept || (score_q < new_score_i);

  assign link_o = '{score: score_q, index: index_q, valid: valid_q, kept: kept, beat: beat};

  // next entry of this cell
  always_comb begin
    score_d = score_q;
    index_d = index_q;
    valid_d = valid_q;
    if (ctl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctl_i.shift) begin
      score_d = next_i.score;
      index_d = next_i.index;
      valid_d = next_i.valid;
    end else begin
      if (ctl_i.ins) begin
        if (!in_keep_i) begin
          valid_d = 1'b0;
        end else if (beat && !prev_i.beat) begin
          score_d = new_score_i;
          index_d = new_index_i;
          valid_d = 1'b1;
        end else if (beat) begin
          score_d = prev_i.score;
          index_d = prev_i.index;
          valid_d = prev_i.kept;
        end
      end
      if (ctl_i.trim && !in_keep_i) begin
        valid_d = 1'b0;
      end
    end
  end

  // occupancy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // entry payload
  always_ff @(posedge clk_i) begin
    score_q <= score_d;
    index_q <= index_d;
  end

endmodule

>>> rtl/thresholded_top_k_selector_unit.sv
// Streaming top-K selector built as a sorted chain of insertion cells.
// Collecting: one score word accepted per cycle; every cell compares against it in parallel.
// Latency: the first result is offered in the cycle after the word marked last is accepted.
// Draining: one result per accepted output cycle (n results, or one empty result); input is
// held off until the cycle after the final result is accepted.
// Reset empties the chain, zeroes the position, sets keep_count to 1 and threshold to 0.
module thresholded_top_k_selector_unit
  import tks_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [REG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [SCORE_W-1:0]    score_i,
  input  logic                  last_score_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [IDX_W-1:0]      class_index_o,
  output logic [SCORE_W-1:0]    kept_score_o,
  output logic                  last_result_o,
  output logic                  none_kept_o
);

  state_e                state_q, state_d;
  logic [KEEP_CFG_W-1:0] keep_count_q;
  logic [SCORE_W-1:0]    threshold_q;
  logic [POS_W-1:0]      pos_q, pos_d;
  logic [KEEP_W-1:0]     keep_eff;
  logic                  in_fire;
  logic                  out_fire;
  cell_ctl_t             ctl;
  link_t                 cell_link [MAX_KEEP];
  link_t                 prev_link [MAX_KEEP];
  link_t                 next_link [MAX_KEEP];
  logic [MAX_KEEP-1:0]   in_keep;
  logic [MAX_KEEP-1:0]   valid_vec;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_count_q <= KEEP_CFG_W'(1);
      threshold_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_KEEP_COUNT:      keep_count_q <= cfg_wdata_i[KEEP_CFG_W-1:0];
        REG_SCORE_THRESHOLD: threshold_q  <= cfg_wdata_i[SCORE_W-1:0];
        default: ;
      endcase
    end
  end

  // effective keep count, zero means one, saturates at the chain length
  always_comb begin
    if (keep_count_q == '0) begin
      keep_eff = KEEP_W'(1);
    end else if (int'(keep_count_q) > MAX_KEEP) begin
      keep_eff = KEEP_W'(MAX_KEEP);
    end else begin
      keep_eff = KEEP_W'(keep_count_q);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_COLLECT: if (in_fire && last_score_i) state_d = ST_DRAIN;
      ST_DRAIN:   if (out_fire && last_result_o) state_d = ST_COLLECT;
      default:    state_d = ST_COLLECT;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_COLLECT: in_ready_o  = 1'b1;
      ST_DRAIN:   out_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_COLLECT;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;

  // chain commands
  assign ctl.ins   = in_fire && (score_i >= threshold_q);
  assign ctl.trim  = in_fire && last_score_i;
  assign ctl.shift = out_fire && !last_result_o;
  assign ctl.clear = out_fire && last_result_o;

  // position counter
  always_comb begin
    pos_d = pos_q;
    if (ctl.clear) begin
      pos_d = '0;
    end else if (in_fire) begin
      pos_d = (int'(pos_q) == MAX_VECTOR - 1) ? '0 : pos_q + POS_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  // chain of cells, head holds the best score
  for (genvar g = 0; g < MAX_KEEP; g++) begin : g_cell
    assign in_keep[g]   = KEEP_W'(g) < keep_eff;
    assign valid_vec[g] = cell_link[g].valid;

    if (g == 0) begin : g_head
      assign prev_link[g] = '0;
    end else begin : g_body
      assign prev_link[g] = cell_link[g-1];
    end

    if (g == MAX_KEEP - 1) begin : g_tail
      assign next_link[g] = '0;
    end else begin : g_inner
      assign next_link[g] = cell_link[g+1];
    end

    tks_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .in_keep_i   (in_keep[g]),
      .new_score_i (score_i),
      .new_index_i (pos_q),
      .prev_i      (prev_link[g]),
      .next_i      (next_link[g]),
      .link_o      (cell_link[g])
    );
  end

  // result word comes from the head cell
  assign none_kept_o   = !cell_link[0].valid;
  assign last_result_o = none_kept_o || !next_link[0].valid;
  assign kept_score_o  = none_kept_o ? '0 : cell_link[0].score;
  assign class_index_o = none_kept_o ? '0 : IDX_W'(cell_link[0].index);

  // checks
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input and output sides open at once");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && none_kept_o) |-> last_result_o)
    else $error("empty result not flagged last");

  a_run_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && last_result_o) |=> (pos_q == '0 && valid_vec == '0))
    else $error("run end did not clear chain and position");

  a_valid_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot({1'b0, valid_vec} + {{MAX_KEEP{1'b0}}, 1'b1}))
    else $error("held entries are not a prefix of the chain");

endmodule
